[rtl/cfa_pkg.sv]
// ----------------------------------------------------------------------------
// cfa_pkg: shared types and constants of the complex arithmetic unit
// Operation and status codes, pipeline item types, CORDIC angle table and
// saturation and rounding helpers.
// ----------------------------------------------------------------------------
package cfa_pkg;

  localparam int DataW       = 32;
  localparam int FracW       = 16;
  localparam int AngFrac     = 30;
  localparam int NumCells    = 32;
  localparam int CordicSteps = 31;
  localparam int CordW       = 36;
  localparam int SqRemW      = 34;
  localparam int RndShift    = AngFrac - FracW;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_CONJ  = 3'd4,
    OP_MAG   = 3'd5,
    OP_ANGLE = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIVZ = 2'd1,
    ST_SAT  = 2'd2
  } st_e;

  typedef logic signed [DataW-1:0] word_t;
  typedef logic [AngFrac-1:0] atan_arr_t [CordicSteps];

  localparam atan_arr_t AtanTab = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
    30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1
  };

  localparam logic signed [CordW-1:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [CordW-1:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [CordW-1:0] RndHalf   = 36'sd1 <<< (RndShift - 1);

  localparam logic signed [2*DataW:0] WideMax = (65'sd1 <<< (DataW - 1)) - 65'sd1;
  localparam logic signed [2*DataW:0] WideMin = -(65'sd1 <<< (DataW - 1));
  localparam word_t WordMax = {1'b0, {(DataW-1){1'b1}}};
  localparam word_t WordMin = {1'b1, {(DataW-1){1'b0}}};

  typedef struct packed {
    logic  sat;
    word_t w;
  } satw_t;

  typedef struct packed {
    op_e   op;
    word_t ar;
    word_t ai;
    word_t br;
    word_t bi;
  } req_t;

  typedef struct packed {
    op_e                       op;
    word_t                     ar;
    word_t                     ai;
    word_t                     er;
    word_t                     ei;
    logic                      esat;
    logic signed [2*DataW-1:0] p_rr;
    logic signed [2*DataW-1:0] p_ii;
    logic signed [2*DataW-1:0] p_ri;
    logic signed [2*DataW-1:0] p_ir;
    logic [2*DataW-1:0]        sq_0;
    logic [2*DataW-1:0]        sq_1;
  } prod_t;

  typedef struct packed {
    op_e                     op;
    word_t                   ar;
    word_t                   ai;
    word_t                   er;
    word_t                   ei;
    logic                    esat;
    logic signed [2*DataW:0] s_r;
    logic signed [2*DataW:0] s_i;
    logic [2*DataW-1:0]      d;
  } sum_t;

  typedef struct packed {
    op_e                      op;
    word_t                    er;
    word_t                    ei;
    logic                     esat;
    logic                     edz;
    logic                     edone;
    logic [2*DataW-1:0]       dv;
    logic                     ovf_r;
    logic                     ovf_i;
    logic                     neg_r;
    logic                     neg_i;
    logic [2*DataW-1:0]       rem_r;
    logic [2*DataW-1:0]       rem_i;
    logic [DataW-1:0]         nlo_r;
    logic [DataW-1:0]         nlo_i;
    logic [DataW-1:0]         q_r;
    logic [DataW-1:0]         q_i;
    logic [2*DataW-1:0]       sq_bits;
    logic [SqRemW-1:0]        sq_rem;
    logic [DataW-1:0]         root;
    logic signed [CordW-1:0]  cx;
    logic signed [CordW-1:0]  cy;
    logic signed [CordW-1:0]  cz;
  } cell_t;

  typedef struct packed {
    st_e   st;
    word_t ri;
    word_t rr;
  } res_t;

  function automatic satw_t sat_w(input logic signed [2*DataW:0] v);
    satw_t r;
    r.sat = 1'b0;
    r.w   = v[DataW-1:0];
    if (v > WideMax) begin
      r.sat = 1'b1;
      r.w   = WordMax;
    end else if (v < WideMin) begin
      r.sat = 1'b1;
      r.w   = WordMin;
    end
    return r;
  endfunction

  // round half up from Q2.30 down to the output fraction
  function automatic logic signed [CordW-1:0] ang_rnd(input logic signed [CordW-1:0] z);
    logic signed [CordW-1:0] t;
    t = z + RndHalf;
    return t >>> RndShift;
  endfunction

  localparam logic signed [CordW-1:0] PiF     = ang_rnd(PiQ30);
  localparam logic signed [CordW-1:0] HalfPiF = ang_rnd(HalfPiQ30);

endpackage

[rtl/cfa_prep.sv]
// ----------------------------------------------------------------------------
// cfa_prep: operand front end
// Three stages: products and simple results, sums and divisor, then signs,
// overflow check and seeding of the divider, root and CORDIC cells.
// ----------------------------------------------------------------------------
module cfa_prep import cfa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  vld_i,
  input  req_t  req_i,
  output logic  vld_o,
  output cell_t cell_o
);

  prod_t p1_d, p1_q;
  sum_t  p2_d, p2_q;
  cell_t p3_d, p3_q;
  logic  v1_q, v2_q, v3_q;

  // stage 1: multipliers and the simple operations (add, subtract, conjugate)
  always_comb begin
    word_t u, v;
    satw_t t0, t1;
    u = (req_i.op == OP_DIV) ? req_i.br : req_i.ai;
    v = (req_i.op == OP_DIV) ? req_i.bi : req_i.ai;
    if (req_i.op != OP_DIV) u = req_i.ar;
    p1_d.op   = req_i.op;
    p1_d.ar   = req_i.ar;
    p1_d.ai   = req_i.ai;
    p1_d.p_rr = (2*DataW)'(req_i.ar) * (2*DataW)'(req_i.br);
    p1_d.p_ii = (2*DataW)'(req_i.ai) * (2*DataW)'(req_i.bi);
    p1_d.p_ri = (2*DataW)'(req_i.ar) * (2*DataW)'(req_i.bi);
    p1_d.p_ir = (2*DataW)'(req_i.ai) * (2*DataW)'(req_i.br);
    p1_d.sq_0 = (2*DataW)'(u) * (2*DataW)'(u);
    p1_d.sq_1 = (2*DataW)'(v) * (2*DataW)'(v);
    t0 = '0;
    t1 = '0;
    case (req_i.op)
      OP_ADD: begin
        t0 = sat_w((2*DataW+1)'(req_i.ar) + (2*DataW+1)'(req_i.br));
        t1 = sat_w((2*DataW+1)'(req_i.ai) + (2*DataW+1)'(req_i.bi));
      end
      OP_SUB: begin
        t0 = sat_w((2*DataW+1)'(req_i.ar) - (2*DataW+1)'(req_i.br));
        t1 = sat_w((2*DataW+1)'(req_i.ai) - (2*DataW+1)'(req_i.bi));
      end
      OP_CONJ: begin
        t0.w = req_i.ar;
        t1   = sat_w(-(2*DataW+1)'(req_i.ai));
      end
      default: begin
        t0 = '0;
        t1 = '0;
      end
    endcase
    p1_d.er   = t0.w;
    p1_d.ei   = t1.w;
    p1_d.esat = t0.sat | t1.sat;
  end

  // stage 2: cross sums and |b|^2 or |a|^2
  always_comb begin
    p2_d.op   = p1_q.op;
    p2_d.ar   = p1_q.ar;
    p2_d.ai   = p1_q.ai;
    p2_d.er   = p1_q.er;
    p2_d.ei   = p1_q.ei;
    p2_d.esat = p1_q.esat;
    p2_d.d    = p1_q.sq_0 + p1_q.sq_1;
    if (p1_q.op == OP_DIV) begin
      p2_d.s_r = (2*DataW+1)'(p1_q.p_rr) + (2*DataW+1)'(p1_q.p_ii);
      p2_d.s_i = (2*DataW+1)'(p1_q.p_ir) - (2*DataW+1)'(p1_q.p_ri);
    end else begin
      p2_d.s_r = (2*DataW+1)'(p1_q.p_rr) - (2*DataW+1)'(p1_q.p_ii);
      p2_d.s_i = (2*DataW+1)'(p1_q.p_ri) + (2*DataW+1)'(p1_q.p_ir);
    end
  end

  // stage 3: seed the cells
  always_comb begin
    logic signed [2*DataW:0] ab_r, ab_i;
    logic [2*DataW-1:0]      hi_r, hi_i;
    logic signed [CordW-1:0] x, y;
    satw_t                   m0, m1;
    ab_r = p2_q.s_r[2*DataW] ? -$signed(p2_q.s_r) : $signed(p2_q.s_r);
    ab_i = p2_q.s_i[2*DataW] ? -$signed(p2_q.s_i) : $signed(p2_q.s_i);
    hi_r = 64'(ab_r[2*DataW-1:FracW]);
    hi_i = 64'(ab_i[2*DataW-1:FracW]);
    x    = CordW'(p2_q.ar);
    y    = CordW'(p2_q.ai);
    m0   = sat_w($signed(p2_q.s_r) >>> FracW);
    m1   = sat_w($signed(p2_q.s_i) >>> FracW);

    p3_d         = '0;
    p3_d.op      = p2_q.op;
    p3_d.dv      = p2_q.d;
    p3_d.neg_r   = p2_q.s_r[2*DataW];
    p3_d.neg_i   = p2_q.s_i[2*DataW];
    p3_d.ovf_r   = hi_r >= p2_q.d;
    p3_d.ovf_i   = hi_i >= p2_q.d;
    p3_d.rem_r   = hi_r;
    p3_d.rem_i   = hi_i;
    p3_d.nlo_r   = {ab_r[FracW-1:0], {(DataW-FracW){1'b0}}};
    p3_d.nlo_i   = {ab_i[FracW-1:0], {(DataW-FracW){1'b0}}};
    p3_d.sq_bits = p2_q.d;
    p3_d.cx      = x;
    p3_d.cy      = y;

    case (p2_q.op)
      OP_ADD, OP_SUB, OP_CONJ: begin
        p3_d.edone = 1'b1;
        p3_d.er    = p2_q.er;
        p3_d.ei    = p2_q.ei;
        p3_d.esat  = p2_q.esat;
      end
      OP_MUL: begin
        p3_d.edone = 1'b1;
        p3_d.er    = m0.w;
        p3_d.ei    = m1.w;
        p3_d.esat  = m0.sat | m1.sat;
      end
      OP_DIV: begin
        if (p2_q.d == '0) begin
          p3_d.edone = 1'b1;
          p3_d.edz   = 1'b1;
        end
      end
      OP_MAG: begin
        p3_d.edone = 1'b0;
      end
      OP_ANGLE: begin
        priority if (y == '0) begin
          p3_d.edone = 1'b1;
          p3_d.er    = (x < 0) ? DataW'(PiF) : '0;
        end else if (x == '0) begin
          p3_d.edone = 1'b1;
          p3_d.er    = (y > 0) ? DataW'(HalfPiF) : DataW'(-HalfPiF);
        end else if (x < 0) begin
          // pre-rotate into the right half plane
          if (y >= 0) begin
            p3_d.cx = y;
            p3_d.cy = -x;
            p3_d.cz = HalfPiQ30;
          end else begin
            p3_d.cx = -y;
            p3_d.cy = x;
            p3_d.cz = -HalfPiQ30;
          end
        end else begin
          p3_d.cz = '0;
        end
      end
      default: begin
        p3_d.edone = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
      p3_q <= p3_d;
    end
  end

  assign vld_o  = v3_q;
  assign cell_o = p3_q;

endmodule

[rtl/cfa_cell.sv]
// ----------------------------------------------------------------------------
// cfa_cell: one step of the iterative chain
// Holds one item and advances it by one restoring-divide step on both lanes,
// one root digit and, in all but the last cell, one CORDIC vectoring rotation.
// ----------------------------------------------------------------------------
module cfa_cell import cfa_pkg::*; #(
  parameter int Idx = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  vld_i,
  input  cell_t cell_i,
  output logic  vld_o,
  output cell_t cell_o
);

  cell_t                   cell_d, cell_q;
  logic                    vld_q;
  logic signed [CordW-1:0] cx_n, cy_n, cz_n;

  if (Idx < CordicSteps) begin : g_rot
    always_comb begin
      logic signed [CordW-1:0] x, y, z, dx, dy, at;
      x  = cell_i.cx;
      y  = cell_i.cy;
      z  = cell_i.cz;
      dx = y >>> Idx;
      dy = x >>> Idx;
      at = CordW'(AtanTab[Idx]);
      if (y > 0) begin
        cx_n = x + dx;
        cy_n = y - dy;
        cz_n = z + at;
      end else begin
        cx_n = x - dx;
        cy_n = y + dy;
        cz_n = z - at;
      end
    end
  end else begin : g_pass
    assign cx_n = cell_i.cx;
    assign cy_n = cell_i.cy;
    assign cz_n = cell_i.cz;
  end

  always_comb begin
    logic [2*DataW:0]  r2_r, r2_i, dvx;
    logic              ge_r, ge_i, sq_ge;
    logic [SqRemW+1:0] sr2, trial;
    cell_d = cell_i;

    dvx  = {1'b0, cell_i.dv};
    r2_r = {cell_i.rem_r, cell_i.nlo_r[DataW-1]};
    r2_i = {cell_i.rem_i, cell_i.nlo_i[DataW-1]};
    ge_r = r2_r >= dvx;
    ge_i = r2_i >= dvx;
    cell_d.rem_r = ge_r ? (2*DataW)'(r2_r - dvx) : r2_r[2*DataW-1:0];
    cell_d.rem_i = ge_i ? (2*DataW)'(r2_i - dvx) : r2_i[2*DataW-1:0];
    cell_d.q_r   = {cell_i.q_r[DataW-2:0], ge_r};
    cell_d.q_i   = {cell_i.q_i[DataW-2:0], ge_i};
    cell_d.nlo_r = {cell_i.nlo_r[DataW-2:0], 1'b0};
    cell_d.nlo_i = {cell_i.nlo_i[DataW-2:0], 1'b0};

    // one root digit per cell, two radicand bits in
    sr2   = {cell_i.sq_rem, cell_i.sq_bits[2*DataW-1 -: 2]};
    trial = {{(SqRemW-DataW){1'b0}}, cell_i.root, 2'b01};
    sq_ge = sr2 >= trial;
    cell_d.sq_rem  = sq_ge ? SqRemW'(sr2 - trial) : sr2[SqRemW-1:0];
    cell_d.root    = {cell_i.root[DataW-2:0], sq_ge};
    cell_d.sq_bits = {cell_i.sq_bits[2*DataW-3:0], 2'b00};

    cell_d.cx = cx_n;
    cell_d.cy = cy_n;
    cell_d.cz = cz_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign vld_o  = vld_q;
  assign cell_o = cell_q;

endmodule

[rtl/cfa_post.sv]
// ----------------------------------------------------------------------------
// cfa_post: result formatting and output register
// Picks the finished value per operation, applies saturation and angle
// rounding and builds the status code.
// ----------------------------------------------------------------------------
module cfa_post import cfa_pkg::*; (
  input  logic  clk_i,
  input  logic  load_i,
  input  cell_t cell_i,
  output res_t  res_o
);

  localparam logic [DataW:0] DivLimPos = {2'b00, {(DataW-1){1'b1}}};
  localparam logic [DataW:0] DivLimNeg = {2'b01, {(DataW-1){1'b0}}};

  res_t res_d, res_q;

  function automatic satw_t div_lane(input logic neg, input logic ovf,
                                     input logic [DataW-1:0] q);
    logic [DataW:0] lim;
    logic [DataW:0] m;
    satw_t          r;
    lim   = neg ? DivLimNeg : DivLimPos;
    m     = {1'b0, q};
    r.sat = 1'b0;
    if (ovf || (m > lim)) begin
      r.sat = 1'b1;
      m     = lim;
    end
    r.w = neg ? DataW'(-m) : m[DataW-1:0];
    return r;
  endfunction

  always_comb begin
    satw_t                   l0, l1;
    logic signed [CordW-1:0] z;
    logic                    sat, dz;
    l0  = '0;
    l1  = '0;
    z   = ang_rnd(cell_i.cz);
    sat = 1'b0;
    dz  = 1'b0;
    if (cell_i.edone) begin
      l0.w = cell_i.er;
      l1.w = cell_i.ei;
      sat  = cell_i.esat;
      dz   = cell_i.edz;
    end else begin
      case (cell_i.op)
        OP_DIV: begin
          l0  = div_lane(cell_i.neg_r, cell_i.ovf_r, cell_i.q_r);
          l1  = div_lane(cell_i.neg_i, cell_i.ovf_i, cell_i.q_i);
          sat = l0.sat | l1.sat;
        end
        OP_MAG: begin
          if (cell_i.root[DataW-1]) begin
            l0.w = WordMax;
            sat  = 1'b1;
          end else begin
            l0.w = cell_i.root;
          end
        end
        OP_ANGLE: begin
          if (z > PiF) z = PiF;
          if (z <= -PiF) z = -PiF + 1;
          l0  = sat_w((2*DataW+1)'(z));
          sat = l0.sat;
        end
        default: begin
          sat = 1'b0;
        end
      endcase
    end
    res_d.rr = l0.w;
    res_d.ri = l1.w;
    res_d.st = dz ? ST_DIVZ : (sat ? ST_SAT : ST_OK);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

[rtl/complex_fixed_arith_unit_top.sv]
// ----------------------------------------------------------------------------
// complex_fixed_arith_unit_top: pipelined complex Q16.16 arithmetic unit
// Add, subtract, multiply, divide, conjugate, magnitude and angle of complex
// operands on a stream, one item per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries the operation code in tuser and the operands a, b in
//   tdata; m_axis returns the complex result in tdata and the status
//   (ok, divide by zero, saturated) in tuser.
//   Every item passes from its accept edge to m_axis_tvalid through three
//   front stages (multipliers, sums, seeding), a chain of 32 cells doing one
//   divide step, one root digit and, bar the last cell, one CORDIC rotation
//   each, and the output register. An item may be accepted in every cycle in
//   which the chain moves. The whole chain advances together; it holds only
//   when its last cell has an item and the output register is full and not
//   being taken, so input is still accepted while a result waits if the chain
//   has gaps. Reset clears all valid flags; no item is in flight after reset.
// ----------------------------------------------------------------------------
module complex_fixed_arith_unit_top import cfa_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // a_real, a_imag, b_real, b_imag
  input  logic [2:0]   s_axis_tuser,  // operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // res_real, res_imag
  output logic [1:0]   m_axis_tuser   // status
);

  logic            en;
  logic            load;
  logic            out_vld_d, out_vld_q;
  req_t            req;
  res_t            res;
  logic [NumCells:0] vld;
  cell_t           cd [NumCells+1];

  assign req.op = op_e'(s_axis_tuser);
  assign req.ar = s_axis_tdata[31:0];
  assign req.ai = s_axis_tdata[63:32];
  assign req.br = s_axis_tdata[95:64];
  assign req.bi = s_axis_tdata[127:96];

  // chain moves unless its last item is blocked by a stalled output
  assign en   = !vld[NumCells] || !out_vld_q || m_axis_tready;
  assign load = en && vld[NumCells];

  cfa_prep u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid),
    .req_i  (req),
    .vld_o  (vld[0]),
    .cell_o (cd[0])
  );

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    cfa_cell #(.Idx(k)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vld[k]),
      .cell_i (cd[k]),
      .vld_o  (vld[k+1]),
      .cell_o (cd[k+1])
    );
  end

  cfa_post u_post (
    .clk_i  (clk_i),
    .load_i (load),
    .cell_i (cd[NumCells]),
    .res_o  (res)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {res.ri, res.rr};
  assign m_axis_tuser  = res.st;

endmodule
